/* hw/rtl/hkn_pkg.sv */
package hkn_pkg;

    localparam int NUM_KEYS_DEF  = 40;
    localparam int KEY_W         = 6;
    localparam int READ_W        = 16;
    localparam int NOTE_W        = 7;
    localparam int VEL_W         = 7;
    localparam int CHAN_W        = 4;
    localparam int TALLY_W       = 7;
    localparam int INTEN_W       = 11;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [TALLY_W-1:0] TALLY_MAX     = 7'd64;
    localparam logic [INTEN_W-1:0] INTENSITY_MAX = 11'd1024;
    localparam logic [VEL_W-1:0]   VEL_SCALE     = 7'd126;
    localparam int                 VEL_SHIFT     = 10;
    localparam logic [READ_W-1:0]  READ_MAX      = 16'hFFFF;

    localparam logic [READ_W-1:0]  PRESS_RST     = 16'd0;
    localparam logic [READ_W-1:0]  RELEASE_RST   = 16'hFFFF;
    localparam logic [VEL_W-1:0]   TABLE_VEL_RST = 7'd100;
    localparam logic [CHAN_W-1:0]  CHANNEL_RST   = 4'd0;

    typedef enum logic [1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_REEVAL  = 2'd1,
        KIND_SILENCE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        DIR_NEUTRAL = 2'd0,
        DIR_PUSH    = 2'd1,
        DIR_PULL    = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_ON   = 2'd1,
        EV_OFF  = 2'd2
    } event_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PRESS     = 2'd0,
        CFG_RELEASE   = 2'd1,
        CFG_TABLE_VEL = 2'd2,
        CFG_CHANNEL   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [KEY_W-1:0]   key;
        logic [READ_W-1:0]  reading;
        logic               frame_start;
        logic               wing_known;
        logic [1:0]         bellows;
        logic               table_mode;
        logic [INTEN_W-1:0] intensity;
        logic [NOTE_W-1:0]  push_note;
        logic               push_has_note;
        logic [NOTE_W-1:0]  pull_note;
        logic               pull_has_note;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         note_event;
        logic [CHAN_W-1:0]  channel;
        logic [NOTE_W-1:0]  pitch;
        logic [VEL_W-1:0]   velocity;
        logic [TALLY_W-1:0] held_count;
    } out_beat_t;

    typedef struct packed {
        logic [READ_W-1:0] press_level;
        logic [READ_W-1:0] release_level;
        logic [VEL_W-1:0]  table_velocity;
        logic [CHAN_W-1:0] midi_channel;
    } cfg_t;

    typedef struct packed {
        logic [READ_W-1:0] lowest;
        logic              down;
        logic              sounding;
        logic [NOTE_W-1:0] pitch;
    } key_state_t;

    typedef struct packed {
        logic              we;
        logic [KEY_W-1:0]  key;
        logic [READ_W-1:0] lowest;
        logic              down;
        logic              sounding;
        logic [NOTE_W-1:0] pitch;
    } key_update_t;

endpackage

/* hw/rtl/hkn_state.sv */
module hkn_state #(
    parameter int NUM_KEYS = hkn_pkg::NUM_KEYS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic [hkn_pkg::KEY_W-1:0]   rd_key,
    input  logic [hkn_pkg::KEY_W-1:0]   cur_key,
    input  logic                        commit,
    input  hkn_pkg::key_update_t        upd,
    output hkn_pkg::key_state_t         cur_state
);

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [hkn_pkg::READ_W-1:0] low_mem   [NUM_KEYS];
    logic [hkn_pkg::NOTE_W-1:0] pitch_mem [NUM_KEYS];

    logic [hkn_pkg::READ_W-1:0] rd_low_reg;
    logic [hkn_pkg::NOTE_W-1:0] rd_pitch_reg;

    logic [NUM_KEYS-1:0] low_valid_reg;
    logic [NUM_KEYS-1:0] sounding_reg;
    logic [NUM_KEYS-1:0] down_reg;

    logic             wr;
    logic             fwd;
    logic [IDX_W-1:0] widx;
    logic [IDX_W-1:0] ridx;
    logic [IDX_W-1:0] cidx;

    assign wr   = commit && upd.we;
    assign fwd  = wr && (upd.key == rd_key);
    assign widx = upd.key[IDX_W-1:0];
    assign ridx = rd_key[IDX_W-1:0];
    assign cidx = cur_key[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr) begin
            low_mem[widx]   <= upd.lowest;
            pitch_mem[widx] <= upd.pitch;
        end
        if (rd_en) begin
            // same-edge write bypass
            rd_low_reg   <= fwd ? upd.lowest : low_mem[ridx];
            rd_pitch_reg <= fwd ? upd.pitch  : pitch_mem[ridx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_valid_reg <= '0;
            sounding_reg  <= '0;
            down_reg      <= '0;
        end else if (wr) begin
            low_valid_reg[widx] <= 1'b1;
            sounding_reg[widx]  <= upd.sounding;
            down_reg[widx]      <= upd.down;
        end
    end

    always_comb begin
        cur_state.lowest   = low_valid_reg[cidx] ? rd_low_reg : hkn_pkg::READ_MAX;
        cur_state.down     = down_reg[cidx];
        cur_state.sounding = sounding_reg[cidx];
        cur_state.pitch    = rd_pitch_reg;
    end

endmodule

/* hw/rtl/hkn_eval.sv */
module hkn_eval #(
    parameter int NUM_KEYS = hkn_pkg::NUM_KEYS_DEF
) (
    input  hkn_pkg::in_beat_t             item,
    input  hkn_pkg::key_state_t           ks,
    input  hkn_pkg::cfg_t                 cfg,
    input  logic [hkn_pkg::TALLY_W-1:0]   tally,
    output hkn_pkg::out_beat_t            result,
    output hkn_pkg::key_update_t          upd,
    output logic [hkn_pkg::TALLY_W-1:0]   tally_next
);

    localparam int PROD_W = hkn_pkg::INTEN_W + hkn_pkg::VEL_W;

    logic                         key_ok;
    logic [1:0]                   dir;
    logic                         has_note;
    logic [hkn_pkg::NOTE_W-1:0]   sel_note;
    logic                         can_on;
    logic [hkn_pkg::INTEN_W-1:0]  inten_sat;
    logic [PROD_W-1:0]            prod;
    logic [hkn_pkg::VEL_W-1:0]    vel_on;
    logic [hkn_pkg::READ_W-1:0]   low_new;
    logic [hkn_pkg::TALLY_W-1:0]  tally0;
    logic                         do_on;
    logic                         do_off;

    assign key_ok = int'(item.key) < NUM_KEYS;

    always_comb begin
        if (item.table_mode) begin
            dir = hkn_pkg::DIR_PULL;
        end else if (item.bellows == 2'd3) begin
            dir = hkn_pkg::DIR_NEUTRAL;
        end else begin
            dir = item.bellows;
        end
    end

    assign has_note  = (dir == hkn_pkg::DIR_PUSH) ? item.push_has_note : item.pull_has_note;
    assign sel_note  = (dir == hkn_pkg::DIR_PUSH) ? item.push_note : item.pull_note;
    assign can_on    = !ks.sounding && (dir != hkn_pkg::DIR_NEUTRAL)
                       && item.wing_known && has_note;

    assign inten_sat = (item.intensity > hkn_pkg::INTENSITY_MAX) ? hkn_pkg::INTENSITY_MAX
                                                                 : item.intensity;
    assign prod      = PROD_W'(inten_sat) * PROD_W'(hkn_pkg::VEL_SCALE);
    assign vel_on    = item.table_mode ? cfg.table_velocity
                     : hkn_pkg::VEL_W'(1) + prod[hkn_pkg::VEL_SHIFT +: hkn_pkg::VEL_W];

    assign low_new   = (item.reading < ks.lowest) ? item.reading : ks.lowest;
    assign tally0    = item.frame_start ? '0 : tally;

    always_comb begin
        upd.we       = 1'b0;
        upd.key      = item.key;
        upd.lowest   = ks.lowest;
        upd.down     = ks.down;
        upd.sounding = ks.sounding;
        upd.pitch    = ks.pitch;
        tally_next   = tally;
        do_on        = 1'b0;
        do_off       = 1'b0;

        case (item.kind)
            hkn_pkg::KIND_SAMPLE: begin
                if (item.wing_known) begin
                    tally_next = tally0;
                    if (key_ok) begin
                        upd.we     = 1'b1;
                        upd.lowest = low_new;
                        if (low_new != '0) begin
                            if (!ks.down && item.reading <= cfg.press_level) begin
                                upd.down = 1'b1;
                                do_on    = can_on;
                            end else if (ks.down && item.reading >= cfg.release_level) begin
                                upd.down = 1'b0;
                                do_off   = ks.sounding;
                            end
                            if (item.push_has_note && upd.down
                                && tally0 < hkn_pkg::TALLY_MAX) begin
                                tally_next = tally0 + hkn_pkg::TALLY_W'(1);
                            end
                        end
                    end
                end
            end
            hkn_pkg::KIND_REEVAL: begin
                if (key_ok) begin
                    upd.we = 1'b1;
                    if (dir == hkn_pkg::DIR_NEUTRAL) begin
                        do_off = ks.sounding;
                    end else if (ks.down) begin
                        do_on = can_on;
                    end
                end
            end
            hkn_pkg::KIND_SILENCE: begin
                if (key_ok) begin
                    upd.we     = 1'b1;
                    upd.down   = 1'b0;
                    tally_next = '0;
                    do_off     = ks.sounding;
                end
            end
            default: begin
            end
        endcase

        if (do_on) begin
            upd.sounding = 1'b1;
            upd.pitch    = sel_note;
        end else if (do_off) begin
            upd.sounding = 1'b0;
        end

        result.channel    = cfg.midi_channel;
        result.held_count = tally_next;
        if (do_on) begin
            result.note_event = hkn_pkg::EV_ON;
            result.pitch      = sel_note;
            result.velocity   = vel_on;
        end else if (do_off) begin
            result.note_event = hkn_pkg::EV_OFF;
            result.pitch      = ks.pitch;
            result.velocity   = '0;
        end else begin
            result.note_event = hkn_pkg::EV_NONE;
            result.pitch      = '0;
            result.velocity   = '0;
        end
    end

endmodule

/* hw/rtl/hall_key_note_tracker.sv */
// Channel   Ports                                  Dir   Notes
// s_        s_valid s_ready s_data (in_beat_t)    in    one key item per beat
// m_        m_valid m_ready m_data (out_beat_t)   out   one result per item
// cfg_      cfg_we cfg_index cfg_data             in    register write, no wait
//
// An input beat passes the input register, with the key memory read, and then
// evaluation into the output register. One item per cycle sustained while m_ready holds.
// A held result stalls the input register only when both are full.
// Reset (synchronous, active low) clears handshake, tally and per-key flags.
module hall_key_note_tracker #(
    parameter int NUM_KEYS = hkn_pkg::NUM_KEYS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  hkn_pkg::in_beat_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output hkn_pkg::out_beat_t                m_data,
    input  logic                              cfg_we,
    input  logic [hkn_pkg::CFG_ADDR_W-1:0]    cfg_index,
    input  logic [hkn_pkg::CFG_DATA_W-1:0]    cfg_data
);

    hkn_pkg::in_beat_t            in_reg;
    logic                         in_valid_reg;
    hkn_pkg::out_beat_t           out_reg;
    logic                         out_valid_reg;
    logic [hkn_pkg::TALLY_W-1:0]  tally_reg;
    logic [hkn_pkg::TALLY_W-1:0]  tally_next;
    hkn_pkg::cfg_t                cfg_reg;

    logic                         advance;
    logic                         commit;
    logic                         accept;
    hkn_pkg::key_state_t          ks;
    hkn_pkg::key_update_t         upd;
    hkn_pkg::out_beat_t           result;

    assign advance = !out_valid_reg || m_ready;
    assign commit  = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    hkn_state #(.NUM_KEYS(NUM_KEYS)) u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_key    (s_data.key),
        .cur_key   (in_reg.key),
        .commit    (commit),
        .upd       (upd),
        .cur_state (ks)
    );

    hkn_eval #(.NUM_KEYS(NUM_KEYS)) u_eval (
        .item       (in_reg),
        .ks         (ks),
        .cfg        (cfg_reg),
        .tally      (tally_reg),
        .result     (result),
        .upd        (upd),
        .tally_next (tally_next)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_data;
        end
        if (commit) begin
            out_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tally_reg     <= '0;
        end else begin
            if (accept) begin
                in_valid_reg <= 1'b1;
            end else if (commit) begin
                in_valid_reg <= 1'b0;
            end
            if (commit) begin
                out_valid_reg <= 1'b1;
                tally_reg     <= tally_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_level    <= hkn_pkg::PRESS_RST;
            cfg_reg.release_level  <= hkn_pkg::RELEASE_RST;
            cfg_reg.table_velocity <= hkn_pkg::TABLE_VEL_RST;
            cfg_reg.midi_channel   <= hkn_pkg::CHANNEL_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                hkn_pkg::CFG_PRESS:     cfg_reg.press_level    <= cfg_data;
                hkn_pkg::CFG_RELEASE:   cfg_reg.release_level  <= cfg_data;
                hkn_pkg::CFG_TABLE_VEL: cfg_reg.table_velocity <= cfg_data[hkn_pkg::VEL_W-1:0];
                hkn_pkg::CFG_CHANNEL:   cfg_reg.midi_channel   <= cfg_data[hkn_pkg::CHAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    a_tally_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tally_reg <= hkn_pkg::TALLY_MAX)
        else $error("held tally above limit");

    a_off_velocity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.note_event == hkn_pkg::EV_OFF) |-> m_data.velocity == '0)
        else $error("note off with nonzero velocity");

    a_quiet_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.note_event == hkn_pkg::EV_NONE)
        |-> (m_data.pitch == '0) && (m_data.velocity == '0))
        else $error("quiet result carries pitch or velocity");

    a_silence_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && (in_reg.kind == hkn_pkg::KIND_SILENCE) && (int'(in_reg.key) < NUM_KEYS)
        |=> tally_reg == '0)
        else $error("silence left tally set");

    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_data.held_count == tally_reg)
        else $error("reported count differs from tally");

endmodule

/* bench/hkn_note_checker.sv */
module hkn_note_checker
    import hkn_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_beat_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_beat_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    localparam logic [7:0] SILENT    = 8'h80;

    cfg_t               regs;
    logic [READ_W-1:0]  key_lowest [NUM_KEYS];
    logic               key_down   [NUM_KEYS];
    logic [7:0]         key_note   [NUM_KEYS];
    logic [TALLY_W-1:0] tally;
    out_beat_t          notes_due  [$];
    int                 mismatches = 0;

    function automatic dir_t effective_dir(input in_beat_t b);
        if (b.table_mode) begin
            return DIR_PULL;
        end
        case (b.bellows)
            DIR_PUSH: return DIR_PUSH;
            DIR_PULL: return DIR_PULL;
            default:  return DIR_NEUTRAL;
        endcase
    endfunction

    function automatic void start_note(input int k, input in_beat_t b, inout out_beat_t r);
        dir_t              d;
        logic              has;
        logic [NOTE_W-1:0] nt;
        int                inten;
        d = effective_dir(b);
        if (key_note[k] != SILENT || d == DIR_NEUTRAL || !b.wing_known) begin
            return;
        end
        if (d == DIR_PUSH) begin
            has = b.push_has_note;
            nt  = b.push_note;
        end else begin
            has = b.pull_has_note;
            nt  = b.pull_note;
        end
        if (!has) begin
            return;
        end
        key_note[k]  = {1'b0, nt};
        r.note_event = EV_ON;
        r.pitch      = nt;
        if (b.table_mode) begin
            r.velocity = regs.table_velocity;
        end else begin
            inten      = (b.intensity > INTENSITY_MAX) ? int'(INTENSITY_MAX) : int'(b.intensity);
            r.velocity = VEL_W'(1 + inten * int'(VEL_SCALE) / int'(INTENSITY_MAX));
        end
    endfunction

    function automatic void stop_note(input int k, inout out_beat_t r);
        if (key_note[k] == SILENT) begin
            return;
        end
        r.note_event = EV_OFF;
        r.pitch      = key_note[k][NOTE_W-1:0];
        r.velocity   = '0;
        key_note[k]  = SILENT;
    endfunction

    function automatic out_beat_t predict_note_result(input in_beat_t b);
        out_beat_t r;
        int        k;
        logic      live;
        r    = '0;
        k    = int'(b.key);
        live = k < NUM_KEYS;
        case (b.kind)
            KIND_SAMPLE: begin
                if (b.wing_known) begin
                    if (b.frame_start) begin
                        tally = '0;
                    end
                    if (live) begin
                        if (b.reading < key_lowest[k]) begin
                            key_lowest[k] = b.reading;
                        end
                        // a minimum of zero marks an unpopulated key
                        if (key_lowest[k] != '0) begin
                            if (!key_down[k] && b.reading <= regs.press_level) begin
                                key_down[k] = 1'b1;
                                start_note(k, b, r);
                            end else if (key_down[k] && b.reading >= regs.release_level) begin
                                key_down[k] = 1'b0;
                                stop_note(k, r);
                            end
                            if (b.push_has_note && key_down[k] && tally < TALLY_MAX) begin
                                tally++;
                            end
                        end
                    end
                end
            end
            KIND_REEVAL: begin
                if (live) begin
                    if (effective_dir(b) == DIR_NEUTRAL) begin
                        stop_note(k, r);
                    end else if (key_down[k]) begin
                        start_note(k, b, r);
                    end
                end
            end
            KIND_SILENCE: begin
                if (live) begin
                    key_down[k] = 1'b0;
                    tally       = '0;
                    stop_note(k, r);
                end
            end
            default: ;
        endcase
        r.channel    = regs.midi_channel;
        r.held_count = tally;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        out_beat_t due;
        if (!aresetn) begin
            regs.press_level    = PRESS_RST;
            regs.release_level  = RELEASE_RST;
            regs.table_velocity = TABLE_VEL_RST;
            regs.midi_channel   = CHANNEL_RST;
            for (int k = 0; k < NUM_KEYS; k++) begin
                key_lowest[k] = READ_MAX;
                key_down[k]   = 1'b0;
                key_note[k]   = SILENT;
            end
            tally = '0;
            notes_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PRESS:     regs.press_level    = cfg_data;
                    CFG_RELEASE:   regs.release_level  = cfg_data;
                    CFG_TABLE_VEL: regs.table_velocity = cfg_data[VEL_W-1:0];
                    CFG_CHANNEL:   regs.midi_channel   = cfg_data[CHAN_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (notes_due.size() == 0) begin
                    $display("%0t: result beat with nothing expected: expected none, actual %p",
                             $time, m_data);
                    mismatches++;
                end else begin
                    due = notes_due.pop_front();
                    check_field("note_event", due.note_event, m_data.note_event);
                    check_field("channel", due.channel, m_data.channel);
                    check_field("pitch", due.pitch, m_data.pitch);
                    check_field("velocity", due.velocity, m_data.velocity);
                    check_field("held_count", due.held_count, m_data.held_count);
                end
            end
            if (s_valid && s_ready) begin
                notes_due.push_back(predict_note_result(s_data));
            end
        end
        pending    <= notes_due.size();
        fail_count <= mismatches;
    end

endmodule

/* bench/tb_hall_key_note_tracker.sv */
module tb_hall_key_note_tracker;
    import hkn_pkg::*;

    localparam int         NUM_KEYS       = NUM_KEYS_DEF;
    localparam int         IDLE_PCT       = 22;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         PHASE_BEATS    = 260;
    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam logic [1:0] BELLOWS_UNUSED = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_beat_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_beat_t             m_data;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    bit                    steady;
    bit                    hold_req;
    int                    beats_sent;
    logic [READ_W-1:0]     press_lv;
    logic [READ_W-1:0]     release_lv;
    logic [NOTE_W-1:0]     push_tab [64];
    logic [NOTE_W-1:0]     pull_tab [64];
    bit                    push_has [64];
    bit                    pull_has [64];
    bit                    finger   [64];
    logic [1:0]            cur_bellows;
    bit                    cur_table;
    logic [INTEN_W-1:0]    cur_inten;

    hall_key_note_tracker #(
        .NUM_KEYS (NUM_KEYS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hkn_note_checker #(
        .NUM_KEYS (NUM_KEYS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL");
        $finish;
    end

    task automatic send_beat(input in_beat_t b);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < IDLE_PCT) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_levels(input int press, input int rel, input int tv, input int ch);
        drain();
        write_reg(CFG_PRESS, CFG_DATA_W'(press));
        write_reg(CFG_RELEASE, CFG_DATA_W'(rel));
        write_reg(CFG_TABLE_VEL, CFG_DATA_W'(tv));
        write_reg(CFG_CHANNEL, CFG_DATA_W'(ch));
        press_lv   = READ_W'(press);
        release_lv = READ_W'(rel);
    endtask

    task automatic steer(input logic [1:0] bel, input bit tm, input int inten);
        cur_bellows = bel;
        cur_table   = tm;
        cur_inten   = INTEN_W'(inten);
    endtask

    function automatic in_beat_t mk(input logic [1:0] kind, input int key, input int rd,
                                    input bit fs);
        in_beat_t b;
        b.kind          = kind;
        b.key           = KEY_W'(key);
        b.reading       = READ_W'(rd);
        b.frame_start   = fs;
        b.wing_known    = 1'b1;
        b.bellows       = cur_bellows;
        b.table_mode    = cur_table;
        b.intensity     = cur_inten;
        b.push_note     = push_tab[key];
        b.push_has_note = push_has[key];
        b.pull_note     = pull_tab[key];
        b.pull_has_note = pull_has[key];
        return b;
    endfunction

    function automatic int finger_reading(input bit down);
        if ($urandom_range(9) == 0 && release_lv > press_lv + 1) begin
            return $urandom_range(release_lv - 1, press_lv + 1);
        end
        if (down) begin
            return (press_lv == 0) ? 1 : $urandom_range(press_lv, 1);
        end
        return $urandom_range(READ_MAX, (release_lv == 0) ? 1 : release_lv);
    endfunction

    task automatic pick_bellows();
        cur_bellows = 2'($urandom_range(3));
        cur_table   = ($urandom_range(4) == 0);
        cur_inten   = ($urandom_range(7) == 0) ? INTEN_W'($urandom_range(2047, 1025))
                                               : INTEN_W'($urandom_range(1024));
    endtask

    task automatic run_phase(input int beats);
        int       goal;
        bit       first;
        in_beat_t b;
        goal = beats_sent + beats;
        while (beats_sent < goal) begin
            if ($urandom_range(3) == 0) begin
                pick_bellows();
                repeat ($urandom_range(8, 1)) begin
                    send_beat(mk(KIND_REEVAL, $urandom_range(NUM_KEYS - 1),
                                 $urandom_range(READ_MAX), 1'b0));
                end
            end
            first = ($urandom_range(99) < 85);
            for (int k = 0; k < NUM_KEYS; k++) begin
                if ($urandom_range(4) == 0) begin
                    finger[k] = !finger[k];
                end
                if ($urandom_range(9) != 0) begin
                    b            = mk(KIND_SAMPLE, k, finger_reading(finger[k]), first);
                    b.wing_known = ($urandom_range(32) != 0);
                    first        = 1'b0;
                    send_beat(b);
                end
            end
            if ($urandom_range(2) == 0) begin
                send_beat(mk(KIND_SILENCE, $urandom_range(NUM_KEYS - 1),
                             $urandom_range(READ_MAX), 1'b0));
            end
            if ($urandom_range(1) == 0) begin
                b               = mk(KIND_SAMPLE, 0, 0, 1'b0);
                b.kind          = 2'($urandom_range(3));
                b.key           = KEY_W'($urandom_range(63));
                b.reading       = READ_W'($urandom_range(READ_MAX, 1));
                b.frame_start   = 1'($urandom_range(1));
                b.wing_known    = ($urandom_range(9) != 0);
                b.bellows       = 2'($urandom_range(3));
                b.table_mode    = 1'($urandom_range(1));
                b.intensity     = INTEN_W'($urandom_range(2047));
                b.push_note     = NOTE_W'($urandom_range(127));
                b.push_has_note = 1'($urandom_range(1));
                b.pull_note     = NOTE_W'($urandom_range(127));
                b.pull_has_note = 1'($urandom_range(1));
                send_beat(b);
            end
        end
    endtask

    initial begin
        in_beat_t b;
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        aresetn    = 1'b0;
        steady     = 1'b0;
        hold_req   = 1'b0;
        beats_sent = 0;
        press_lv   = PRESS_RST;
        release_lv = RELEASE_RST;
        steer(DIR_PUSH, 1'b0, 0);
        for (int k = 0; k < 64; k++) begin
            push_tab[k] = NOTE_W'($urandom_range(127));
            pull_tab[k] = NOTE_W'($urandom_range(127));
            push_has[k] = ($urandom_range(6) != 0);
            pull_has[k] = ($urandom_range(6) != 0);
            finger[k]   = 1'b0;
        end
        for (int k = 0; k <= 6; k++) begin
            push_has[k] = 1'b1;
            pull_has[k] = 1'b1;
        end
        push_has[5] = 1'b0;
        push_tab[6] = NOTE_W'(127);
        pull_tab[2] = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: nothing can be pressed on a live key
        send_beat(mk(KIND_SAMPLE, 7, READ_MAX, 1'b1));
        send_beat(mk(KIND_SAMPLE, 7, 1, 1'b0));

        set_levels(1000, 5000, 127, 15);
        send_beat(mk(KIND_SAMPLE, 0, READ_MAX, 1'b1));
        send_beat(mk(KIND_SAMPLE, 0, 500, 1'b0));
        steer(DIR_NEUTRAL, 1'b0, 0);
        send_beat(mk(KIND_REEVAL, 0, 0, 1'b0));
        steer(DIR_PULL, 1'b0, 1024);
        send_beat(mk(KIND_REEVAL, 0, 0, 1'b0));
        steer(DIR_PUSH, 1'b0, 2047);
        send_beat(mk(KIND_REEVAL, 0, 0, 1'b0));
        send_beat(mk(KIND_SILENCE, 0, 0, 1'b0));
        send_beat(mk(KIND_SILENCE, 0, 0, 1'b0));
        // zero minimum: key 1 is unpopulated from here on
        send_beat(mk(KIND_SAMPLE, 1, 0, 1'b0));
        send_beat(mk(KIND_SAMPLE, 1, 100, 1'b0));
        steer(DIR_PUSH, 1'b1, 300);
        send_beat(mk(KIND_SAMPLE, 2, 1000, 1'b0));
        send_beat(mk(KIND_SAMPLE, 2, 5000, 1'b0));
        steer(BELLOWS_UNUSED, 1'b0, 512);
        send_beat(mk(KIND_SAMPLE, 3, 10, 1'b0));
        steer(DIR_PUSH, 1'b0, 512);
        send_beat(mk(KIND_REEVAL, 3, 0, 1'b0));
        b            = mk(KIND_SAMPLE, 4, 10, 1'b1);
        b.wing_known = 1'b0;
        send_beat(b);
        send_beat(mk(KIND_SAMPLE, 63, 10, 1'b1));
        send_beat(mk(KIND_REEVAL, 50, 0, 1'b0));
        send_beat(mk(KIND_SILENCE, 45, 0, 1'b0));
        send_beat(mk(KIND_UNUSED, 5, 10, 1'b0));
        send_beat(mk(KIND_SAMPLE, 5, 10, 1'b0));
        steer(DIR_PUSH, 1'b0, 1023);
        send_beat(mk(KIND_SAMPLE, 6, 10, 1'b0));
        send_beat(mk(KIND_SAMPLE, 6, READ_MAX, 1'b0));

        set_levels(2000, 6000, 100, 5);
        run_phase(PHASE_BEATS);

        steady = 1'b1;
        set_levels(65535, 0, 0, 15);
        run_phase(PHASE_BEATS);
        steady = 1'b0;

        set_levels(30000, 30001, 127, 0);
        hold_req = 1'b1;
        run_phase(PHASE_BEATS);

        set_levels(100, 65535, 1, 9);
        run_phase(PHASE_BEATS);

        set_levels(12000, 20000, 64, 3);
        run_phase(PHASE_BEATS);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
